### rtl/area_address_pool_picker_assert.svh
// assertion macros for the area address pool picker
`ifndef AREA_ADDRESS_POOL_PICKER_ASSERT_SVH
`define AREA_ADDRESS_POOL_PICKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AAPP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AAPP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AAPP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define AAPP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/aapp_pkg.sv
`default_nettype none
package aapp_pkg;
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRange    = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic       OpLoad     = 1'b0;
  localparam logic       OpQuery    = 1'b1;
  localparam logic [1:0] AddrAreaCount = 2'd0;

  typedef struct packed {
    logic        operation;
    logic [15:0] area_id;
    logic [31:0] range_start;
    logic [31:0] range_size;
    logic [31:0] draw;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
  } rsp_t;
endpackage
`default_nettype wire

### rtl/aapp_if.sv
`default_nettype none
interface aapp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/aapp_fifo.sv
`default_nettype none
// two-entry request queue between front and back
module aapp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire aapp_pkg::req_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output aapp_pkg::req_t     pop_data_o
);
  import aapp_pkg::*;
  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

### rtl/aapp_divider.sv
`default_nettype none
// 32-bit restoring remainder, one quotient bit per cycle
module aapp_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      rem_o
);
  logic [31:0] num_q, den_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q, num_q[31]};
  assign trial   = shifted - {1'b0, den_q};
  assign done_o  = done_q;
  assign rem_o   = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], 1'b0};
      rem_q <= trial[32] ? shifted[31:0] : trial[31:0];
    end
  end
endmodule
`default_nettype wire

### rtl/aapp_engine.sv
`default_nettype none
// back part: area table, block store, modulo and range walk
module aapp_engine #(
  parameter int unsigned MaxAreas  = 1024,
  parameter int unsigned MaxBlocks = 4096
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [10:0]    area_count_i,
  input  wire logic           req_valid_i,
  input  wire aapp_pkg::req_t req_i,
  output logic                req_pop_o,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output aapp_pkg::rsp_t      rsp_o,
  output logic                busy_o
);
  import aapp_pkg::*;
  localparam int AW = (MaxAreas > 1) ? $clog2(MaxAreas) : 1;
  localparam int BW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CW = $clog2(MaxBlocks + 1);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SClear = 4'd1;
  localparam logic [3:0] SRead  = 4'd2;
  localparam logic [3:0] SDec   = 4'd3;
  localparam logic [3:0] SDiv   = 4'd4;
  localparam logic [3:0] SWait  = 4'd5;
  localparam logic [3:0] SBlk   = 4'd6;
  localparam logic [3:0] SCmp   = 4'd7;
  localparam logic [3:0] SOut   = 4'd8;

  // area table packed: valid, total, first, count
  localparam int EW = 1 + 32 + BW + CW;
  logic [EW-1:0] area_mem [MaxAreas];
  logic [63:0]   blk_mem [MaxBlocks];
  logic [EW-1:0] area_rd_q;
  logic [63:0]   blk_rd_q;

  logic [3:0]    state_q;
  logic [AW-1:0] clr_q;
  req_t          cur_q;
  logic [CW-1:0] loaded_q;
  logic [16:0]   last_q;
  logic [31:0]   rem_q, run_q;
  logic [CW-1:0] left_q;
  logic [BW:0]   idx_q;
  rsp_t          rsp_q;
  logic          rsp_v_q;

  logic          a_wr;
  logic [AW-1:0] a_waddr;
  logic [EW-1:0] a_wdata;
  logic          b_wr;
  logic          div_start, div_done;
  logic [31:0]   div_rem;

  logic          e_valid;
  logic [31:0]   e_total;
  logic [BW-1:0] e_first;
  logic [CW-1:0] e_count;
  logic          in_range;
  logic [AW-1:0] cur_area;
  logic [31:0]   diff;
  logic [31:0]   span_end;

  assign {e_valid, e_total, e_first, e_count} = area_rd_q;
  assign in_range = ({5'd0, cur_q.area_id} < {10'd0, area_count_i})
                 && ({16'd0, cur_q.area_id} < 32'(MaxAreas));
  assign cur_area = cur_q.area_id[AW-1:0];
  assign diff     = rem_q - run_q;
  // end of the current range, wrapping like the running count
  assign span_end = run_q + blk_rd_q[31:0];

  aapp_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(cur_q.draw), .divisor_i(e_total),
    .done_o(div_done), .rem_o(div_rem)
  );

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;
  assign req_pop_o   = (state_q == SIdle) && req_valid_i && !rsp_v_q;
  assign busy_o      = (state_q != SIdle) || rsp_v_q;
  assign div_start   = (state_q == SDec) && cur_q.operation == OpQuery && in_range
                    && e_valid && e_total != 32'd0;

  always_comb begin
    a_wr    = 1'b0;
    a_waddr = cur_area;
    a_wdata = area_rd_q;
    b_wr    = 1'b0;
    if (state_q == SClear) begin
      a_wr    = 1'b1;
      a_waddr = clr_q;
      a_wdata = '0;
    end else if (state_q == SDec && cur_q.operation == OpLoad && in_range
                 && loaded_q < CW'(MaxBlocks)) begin
      a_wr = 1'b1;
      b_wr = 1'b1;
      if ({1'b0, cur_q.area_id} != last_q)
        a_wdata = {1'b1, cur_q.range_size, loaded_q[BW-1:0], CW'(1)};
      else
        a_wdata = {1'b1, e_total + cur_q.range_size, e_first, e_count + CW'(1)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_wr) area_mem[a_waddr] <= a_wdata;
    area_rd_q <= area_mem[cur_area];
    if (b_wr) blk_mem[loaded_q[BW-1:0]] <= {cur_q.range_start, cur_q.range_size};
    blk_rd_q <= blk_mem[idx_q[BW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) cur_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      clr_q    <= '0;
      loaded_q <= '0;
      last_q   <= 17'h10000;
      rsp_v_q  <= 1'b0;
      rsp_q    <= '0;
      rem_q    <= '0;
      run_q    <= '0;
      left_q   <= '0;
      idx_q    <= '0;
    end else begin
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      case (state_q)
        SClear: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MaxAreas - 1)) state_q <= SIdle;
        end
        SIdle: if (req_pop_o) state_q <= SRead;
        SRead: state_q <= SDec;
        SDec: begin
          rsp_q.address <= '0;
          if (!in_range) begin
            rsp_q.status <= StRange;
            state_q <= SOut;
          end else if (cur_q.operation == OpLoad) begin
            if (loaded_q >= CW'(MaxBlocks)) rsp_q.status <= StFull;
            else begin
              rsp_q.status <= StOk;
              loaded_q <= loaded_q + CW'(1);
              last_q   <= {1'b0, cur_q.area_id};
            end
            state_q <= SOut;
          end else if (!e_valid || e_total == 32'd0) begin
            rsp_q.status <= StEmpty;
            state_q <= SOut;
          end else begin
            state_q <= SDiv;
          end
        end
        SDiv: state_q <= SWait;
        SWait: if (div_done) begin
          rem_q  <= div_rem;
          run_q  <= '0;
          left_q <= e_count;
          idx_q  <= {1'b0, e_first};
          state_q <= SBlk;
        end
        SBlk: begin
          if (left_q == '0 || idx_q >= (BW+1)'(MaxBlocks)) begin
            rsp_q.status <= StNotFound;
            state_q <= SOut;
          end else state_q <= SCmp;
        end
        SCmp: begin
          if (rem_q >= run_q && rem_q < span_end) begin
            rsp_q.address <= blk_rd_q[63:32] + diff;
            rsp_q.status  <= StOk;
            state_q <= SOut;
          end else begin
            run_q  <= span_end;
            left_q <= left_q - CW'(1);
            idx_q  <= idx_q + (BW+1)'(1);
            state_q <= SBlk;
          end
        end
        SOut: begin
          rsp_v_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/area_address_pool_picker.sv
// flow: a load, rejected or empty request goes read, decode, respond; a query adds a
// bit-serial modulo and a compare per range walked before the response
// throughput: one request at a time; the next starts when the result has been taken
// after reset the area table is cleared entry by entry before requests flow
// reset: asynchronous active low; area_count returns to 1024
`default_nettype none
`include "area_address_pool_picker_assert.svh"
module area_address_pool_picker #(
  parameter int unsigned MAX_AREAS  = 1024,
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aapp_if.sink      req_if,
  aapp_if.source    rsp_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import aapp_pkg::*;
  logic [10:0] area_count_q;
  logic        q_full, q_empty, q_pop, busy;
  req_t        q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrAreaCount) ? {21'd0, area_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) area_count_q <= 11'd1024;
    else if (psel && penable && pwrite && paddr == AddrAreaCount)
      area_count_q <= pwdata[10:0];
  end

  assign req_if.ready = !q_full;

  aapp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(req_if.valid && !q_full), .push_data_i(req_if.data), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .pop_data_o(q_data)
  );

  aapp_engine #(.MaxAreas(MAX_AREAS), .MaxBlocks(MAX_BLOCKS)) u_eng (
    .clk_i, .rst_ni,
    .area_count_i(area_count_q),
    .req_valid_i(!q_empty), .req_i(q_data), .req_pop_o(q_pop),
    .rsp_valid_o(rsp_if.valid), .rsp_ready_i(rsp_if.ready), .rsp_o(rsp_if.data),
    .busy_o(busy)
  );

  `AAPP_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, q_pop, !q_empty)
  `AAPP_ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_pop, !busy)
  `AAPP_ASSERT_IMPL(a_status_legal, clk_i, rst_ni, rsp_if.valid, rsp_if.data.status <= StNotFound)
endmodule
`default_nettype wire
